FILE: rtl/qrot_pkg.sv
// Package with widths, types and arithmetic helpers of the quaternion rotate unit.
`default_nettype none

package qrot_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int OPX_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * OPX_W;
  localparam int TP_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TP_W + 2;

  typedef logic [1:0]                mode_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [OPX_W-1:0]  opx_t;
  typedef logic signed [TP_W-1:0]   tprod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef tprod_t pmat_t [4][4];
  typedef sum_t   svec_t [4];

  typedef struct packed {
    logic  ovf;
    data_t val;
  } sat_t;

  localparam mode_t MODE_PRODUCT   = 2'd0;
  localparam mode_t MODE_ROTATE    = 2'd1;
  localparam mode_t MODE_FRAME     = 2'd2;
  // The unused code decodes as a frame change.
  localparam mode_t MODE_FRAME_ALT = 2'd3;

  // Exact product, then floor division by 2^FRAC_BITS.
  function automatic tprod_t mul_floor(opx_t a, opx_t b);
    logic signed [PROD_W-1:0] full;
    full = PROD_W'(a) * PROD_W'(b);
    return tprod_t'(full[FRAC_BITS +: TP_W]);
  endfunction

  // Hamilton product sums from the table of truncated partial products.
  function automatic svec_t ham_sum(pmat_t p);
    svec_t s;
    s[0] = SUM_W'(p[0][0]) - SUM_W'(p[1][1]) - SUM_W'(p[2][2]) - SUM_W'(p[3][3]);
    s[1] = SUM_W'(p[0][1]) + SUM_W'(p[1][0]) + SUM_W'(p[2][3]) - SUM_W'(p[3][2]);
    s[2] = SUM_W'(p[0][2]) - SUM_W'(p[1][3]) + SUM_W'(p[2][0]) + SUM_W'(p[3][1]);
    s[3] = SUM_W'(p[0][3]) + SUM_W'(p[1][2]) - SUM_W'(p[2][1]) + SUM_W'(p[3][0]);
    return s;
  endfunction

  function automatic sat_t sat32(sum_t v);
    sat_t r;
    sum_t smax;
    sum_t smin;
    smax = sum_t'(data_t'({1'b0, {(DATA_W-1){1'b1}}}));
    smin = sum_t'(data_t'({1'b1, {(DATA_W-1){1'b0}}}));
    if (v > smax) begin
      r.ovf = 1'b1;
      r.val = data_t'(smax[DATA_W-1:0]);
    end else if (v < smin) begin
      r.ovf = 1'b1;
      r.val = data_t'(smin[DATA_W-1:0]);
    end else begin
      r.ovf = 1'b0;
      r.val = data_t'(v[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_rotate_unit.sv
// Top level of the quaternion rotate unit: a five-stage fixed-point pipeline.
`default_nettype none

// Usage: each input transaction carries a mode, a quaternion q (in_quat_*) and
// a second operand p (in_oper_*), all signed fixed point with FRAC_BITS
// fraction bits. Mode product returns q*p; mode rotate returns q*v*conj(q);
// mode frame (and the unused fourth code) returns conj(q)*v*q. In the rotate
// modes in_oper_w is ignored and out_res_w is zero. out_overflow is set when
// any returned or intermediate component saturated to 32 bits.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low. The pipeline has five register stages: input
// operands, first partial products, first sums, second partial products and
// the output register, which a transaction passes through in that order. One
// transaction can be accepted every cycle while out_stall is low; the rate is
// set by the fully pipelined bank of sixteen multipliers in each of the two
// product stages. Each stage advances when it is empty or when the stage after
// it advances, so empty slots close up while out_stall is high and in_stall
// rises only when all five stages hold a transaction.
// A synchronous active-low reset empties every stage; data registers are not
// cleared.
module quaternion_rotate_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire qrot_pkg::mode_t       in_mode,
  input  wire qrot_pkg::data_t       in_quat_w,
  input  wire qrot_pkg::data_t       in_quat_x,
  input  wire qrot_pkg::data_t       in_quat_y,
  input  wire qrot_pkg::data_t       in_quat_z,
  input  wire qrot_pkg::data_t       in_oper_w,
  input  wire qrot_pkg::data_t       in_oper_x,
  input  wire qrot_pkg::data_t       in_oper_y,
  input  wire qrot_pkg::data_t       in_oper_z,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      qrot_pkg::data_t       out_res_w,
  output      qrot_pkg::data_t       out_res_x,
  output      qrot_pkg::data_t       out_res_y,
  output      qrot_pkg::data_t       out_res_z,
  output      logic                  out_overflow
);

  import qrot_pkg::*;

  // Stage valid bits and the ready chain that runs back from the output.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: operand select. The first product uses q or conj(q) on the left,
  // and the second product uses the other one on the right.
  logic rot_nxt;
  logic frame_nxt;
  opx_t a1_nxt [4];
  opx_t b1_nxt [4];
  opx_t c1_nxt [4];
  opx_t q_ext  [4];
  opx_t qc_ext [4];
  opx_t p_ext  [4];

  logic rot1_r;
  opx_t a1_r [4];
  opx_t b1_r [4];
  opx_t c1_r [4];

  always_comb begin
    rot_nxt   = (in_mode != MODE_PRODUCT);
    frame_nxt = (in_mode == MODE_FRAME) || (in_mode == MODE_FRAME_ALT);
    q_ext[0]  = opx_t'(in_quat_w);
    q_ext[1]  = opx_t'(in_quat_x);
    q_ext[2]  = opx_t'(in_quat_y);
    q_ext[3]  = opx_t'(in_quat_z);
    p_ext[0]  = rot_nxt ? opx_t'(0) : opx_t'(in_oper_w);
    p_ext[1]  = opx_t'(in_oper_x);
    p_ext[2]  = opx_t'(in_oper_y);
    p_ext[3]  = opx_t'(in_oper_z);
    // The conjugate negates exactly, so the negation of the most negative
    // value needs the extra bit.
    qc_ext[0] = q_ext[0];
    for (int i = 1; i < 4; i++) begin
      qc_ext[i] = -q_ext[i];
    end
    for (int i = 0; i < 4; i++) begin
      a1_nxt[i] = frame_nxt ? qc_ext[i] : q_ext[i];
      c1_nxt[i] = frame_nxt ? q_ext[i] : qc_ext[i];
      b1_nxt[i] = p_ext[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      rot1_r <= rot_nxt;
      a1_r   <= a1_nxt;
      b1_r   <= b1_nxt;
      c1_r   <= c1_nxt;
    end
  end

  // Stage 2: sixteen truncated partial products of the first Hamilton product.
  pmat_t prod2_nxt;
  pmat_t prod2_r;
  logic  rot2_r;
  opx_t  c2_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod2_nxt[i][j] = mul_floor(a1_r[i], b1_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      prod2_r <= prod2_nxt;
      rot2_r  <= rot1_r;
      c2_r    <= c1_r;
    end
  end

  // Stage 3: sums and saturation of the first product. In product mode this
  // is already the result.
  svec_t sum3;
  sat_t  sat3 [4];
  data_t t3_nxt [4];
  logic  ovf3_nxt;
  data_t t3_r [4];
  logic  ovf3_r;
  logic  rot3_r;
  opx_t  c3_r [4];

  always_comb begin
    sum3     = ham_sum(prod2_r);
    ovf3_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sat3[i]   = sat32(sum3[i]);
      t3_nxt[i] = sat3[i].val;
      ovf3_nxt  = ovf3_nxt | sat3[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      t3_r   <= t3_nxt;
      ovf3_r <= ovf3_nxt;
      rot3_r <= rot2_r;
      c3_r   <= c2_r;
    end
  end

  // Stage 4: partial products of the second Hamilton product, t times the
  // conjugate (rotate) or times q (frame change).
  pmat_t prod4_nxt;
  pmat_t prod4_r;
  data_t t4_r [4];
  logic  ovf4_r;
  logic  rot4_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod4_nxt[i][j] = mul_floor(opx_t'(t3_r[i]), c3_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      prod4_r <= prod4_nxt;
      t4_r    <= t3_r;
      ovf4_r  <= ovf3_r;
      rot4_r  <= rot3_r;
    end
  end

  // Stage 5: second sums and the output register. Only the vector part of the
  // second product is returned and only its saturation counts.
  svec_t sum5;
  sat_t  sat5 [4];
  data_t res_nxt [4];
  logic  ovf5_nxt;
  data_t res_r [4];
  logic  ovf5_r;

  always_comb begin
    sum5 = ham_sum(prod4_r);
    for (int i = 0; i < 4; i++) begin
      sat5[i] = sat32(sum5[i]);
    end
    if (rot4_r) begin
      res_nxt[0] = '0;
      res_nxt[1] = sat5[1].val;
      res_nxt[2] = sat5[2].val;
      res_nxt[3] = sat5[3].val;
      ovf5_nxt   = ovf4_r | sat5[1].ovf | sat5[2].ovf | sat5[3].ovf;
    end else begin
      res_nxt  = t4_r;
      ovf5_nxt = ovf4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      res_r  <= res_nxt;
      ovf5_r <= ovf5_nxt;
    end
  end

  assign out_valid    = v5_r;
  assign out_res_w    = res_r[0];
  assign out_res_x    = res_r[1];
  assign out_res_y    = res_r[2];
  assign out_res_z    = res_r[3];
  assign out_overflow = ovf5_r;

`ifndef SYNTH
  // A transaction blocked in stage 3 keeps the w and z components of its intermediate quaternion and its overflow flag.
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (v3_r && $stable(t3_r[0]) && $stable(t3_r[3]) && $stable(ovf3_r)))
    else $error("stage 3 contents changed while blocked");

  // A transaction that leaves stage 1 arrives in stage 2.
  a_stage1_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> v2_r)
    else $error("transaction lost between stage 1 and stage 2");

  // A rotate-mode transaction entering the output register carries a zero scalar.
  a_rotate_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && rot4_r && rdy5) |=> (out_valid && (out_res_w == '0)))
    else $error("rotate result has a nonzero scalar part");
`endif

endmodule

`default_nettype wire
